### src/gwp_pkg.sv
// Package for the greedy weight partition block.
// Field widths, register map, controller states and the command/status structs.
// No dependencies.
package gwp_pkg;

	localparam int WEIGHT_W = 32;
	localparam int PIDX_W   = 4;
	localparam int POS_W    = 11;
	localparam int PW_W     = 42;
	localparam int PC_W     = 5;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [PC_W-1:0] PC_RESET = PC_W'(2);
	localparam logic [PC_W-1:0] PC_MIN   = PC_W'(2);
	localparam logic [PC_W-1:0] PC_LIMIT = PC_W'(16);

	// register index, taken from paddr[2]
	localparam logic REG_PARTS_COUNT = 1'b0;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_READ,
		ST_ADD,
		ST_MUL1,
		ST_CMP1,
		ST_MUL2,
		ST_CMP2,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic rd;
		logic add;
		logic mul1;
		logic mul2;
		logic step;
		logic cut;
		logic fin;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic cut_hit;
	} dp_status_t;

endpackage

### src/gwp_ifs.sv
// Valid/ready channel interfaces for weight input and part results.
// Depends on gwp_pkg.
interface gwp_in_if;
	import gwp_pkg::*;
	logic                valid;
	logic                ready;
	logic [WEIGHT_W-1:0] weight;
	logic                last;
	modport source(output valid, weight, last, input ready);
	modport sink(input valid, weight, last, output ready);
endinterface

interface gwp_out_if;
	import gwp_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [PIDX_W-1:0]       part_index;
	logic signed [POS_W-1:0] end_position;
	logic [PW_W-1:0]         part_weight;
	logic                    truncated;
	logic                    last_part;
	modport source(output valid, part_index, end_position, part_weight, truncated, last_part,
		input ready);
	modport sink(input valid, part_index, end_position, part_weight, truncated, last_part,
		output ready);
endinterface

### src/greedy_weight_partition_1d.sv
// Greedy 1-D weight partition: loads weights, then splits them into contiguous parts.
// Load: one weight per cycle. Scan: READ, ADD, MUL1, CMP1 per weight; a cut adds MUL2,
// CMP2 (a cut before a weight visits it again); FINAL emits the result after the scan.
// Scan time is set by the single store read port, the shared multiplier and output stalls.
// Reset clears counters, totals and the controller; the weight store is not cleared.
// Depends on gwp_pkg, gwp_ifs, gwp_ctrl, gwp_dp, gwp_ram.
module greedy_weight_partition_1d #(
	parameter int MAX_LEN     = 1024,
	parameter int MAX_PARTS   = 16,
	parameter int WEIGHT_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gwp_pkg::APB_AW-1:0]   paddr,
	input  logic [gwp_pkg::APB_DW-1:0]   pwdata,
	output logic [gwp_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	gwp_in_if.sink                       weights,
	gwp_out_if.source                    parts
);
	import gwp_pkg::*;

	logic [PC_W-1:0] parts_count_q;
	logic            reg_sel;
	dp_cmd_t         cmd;
	dp_status_t      status;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_PARTS_COUNT);
	assign prdata  = reg_sel ? APB_DW'(parts_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			parts_count_q <= PC_RESET;
		else if (psel && penable && pwrite && pready && reg_sel)
			parts_count_q <= pwdata[PC_W-1:0];
	end

	gwp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (weights.valid),
		.in_last  (weights.last),
		.in_ready (weights.ready),
		.out_ready(parts.ready),
		.out_valid(parts.valid),
		.status   (status),
		.cmd      (cmd)
	);

	gwp_dp #(
		.MAX_LEN    (MAX_LEN),
		.MAX_PARTS  (MAX_PARTS),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.weight      (weights.weight),
		.parts_count (parts_count_q),
		.part_index  (parts.part_index),
		.end_position(parts.end_position),
		.part_weight (parts.part_weight),
		.truncated   (parts.truncated),
		.last_part   (parts.last_part)
	);

endmodule

### src/gwp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gwp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

### src/gwp_ctrl.sv
// Controller FSM: load handshake, scan sequencing, result valid flag.
// Depends on gwp_pkg; drives gwp_dp through dp_cmd_t.
module gwp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	input  gwp_pkg::dp_status_t status,
	output gwp_pkg::dp_cmd_t    cmd
);
	import gwp_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.cut || cmd.fin)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						cmd.start = 1'b1;
						state_d   = ST_READ;
					end
				end
			end
			ST_READ: begin
				if (status.scan_done) begin
					state_d = ST_FINAL;
				end else begin
					cmd.rd  = 1'b1;
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_CMP1;
			end
			ST_CMP1: begin
				if (status.cut_hit) begin
					state_d = ST_MUL2;
				end else begin
					cmd.step = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_CMP2;
			end
			ST_CMP2: begin
				if (out_free) begin
					cmd.cut = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_FINAL: begin
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cut || cmd.fin) |-> out_free)
		else $error("result emitted over an untaken result");

	a_cmp2_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP2) |-> ($past(state_q) == ST_MUL2 || $past(state_q) == ST_CMP2))
		else $error("cut decision without second product");

	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_CMP2 || $past(state_q) == ST_FINAL))
		else $error("result valid raised outside an emit state");

endmodule

### src/gwp_dp.sv
// Datapath: weight store, totals, scan position, shared multiplier, result registers.
// Depends on gwp_pkg and gwp_ram.
module gwp_dp #(
	parameter int MAX_LEN     = 1024,
	parameter int MAX_PARTS   = 16,
	parameter int WEIGHT_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gwp_pkg::dp_cmd_t               cmd,
	output gwp_pkg::dp_status_t            status,
	input  logic [gwp_pkg::WEIGHT_W-1:0]   weight,
	input  logic [gwp_pkg::PC_W-1:0]       parts_count,
	output logic [gwp_pkg::PIDX_W-1:0]     part_index,
	output logic signed [gwp_pkg::POS_W-1:0] end_position,
	output logic [gwp_pkg::PW_W-1:0]       part_weight,
	output logic                           truncated,
	output logic                           last_part
);
	import gwp_pkg::*;

	localparam int EW    = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
	localparam int AW    = $clog2(MAX_LEN);
	localparam int CW    = AW + 1;
	localparam int SUM_W = EW + AW;
	localparam int MW    = SUM_W + 1 + PC_W;
	localparam int KMAX  = (MAX_PARTS < 16) ? MAX_PARTS : 16;

	logic [CW-1:0]    load_cnt_q;
	logic [CW-1:0]    pos_q;
	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] rps_q;
	logic [PIDX_W-1:0] part_q;
	logic [PC_W-1:0]  k_q;
	logic             ovf_q;
	logic [EW-1:0]    cur_q;
	logic [MW-1:0]    mul_q;

	logic             full;
	logic [EW-1:0]    w_eff;
	logic [EW-1:0]    rd_data;
	logic [PC_W-1:0]  k_clamp;
	logic [PC_W-1:0]  r;
	logic [SUM_W:0]   span;
	logic [SUM_W:0]   mul_a;
	logic [MW-1:0]    product;
	logic             cut_early;
	logic [SUM_W-1:0] cut_pw;
	logic signed [CW:0] pos_s;
	logic signed [CW:0] cnt_s;
	logic signed [CW:0] one_s;
	logic signed [CW:0] cut_end;
	logic signed [CW:0] fin_end;

	assign full  = (load_cnt_q == CW'(MAX_LEN));
	assign w_eff = weight[EW-1:0];

	gwp_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_LEN)
	) u_store (
		.clk  (clk),
		.we   (cmd.load && !full),
		.waddr(load_cnt_q[AW-1:0]),
		.wdata(w_eff),
		.re   (cmd.rd),
		.raddr(pos_q[AW-1:0]),
		.rdata(rd_data)
	);

	always_comb begin
		if (parts_count < PC_MIN)
			k_clamp = PC_MIN;
		else if (parts_count > PC_W'(KMAX))
			k_clamp = PC_W'(KMAX);
		else
			k_clamp = parts_count;
	end

	// r = parts still to form; span = 2*sum - cur (sum includes cur)
	assign r       = k_q - {1'b0, part_q};
	assign span    = {rps_q, 1'b0} - (SUM_W + 1)'(cur_q);
	assign mul_a   = cmd.mul2 ? span : {1'b0, rps_q};
	assign product = MW'(mul_a) * MW'(r);

	assign status.scan_done = (pos_q == load_cnt_q);
	assign status.cut_hit   = (({1'b0, part_q} + PC_W'(1)) < k_q) && (mul_q > MW'(rem_q));

	assign cut_early = MW'({rem_q, 1'b0}) < mul_q;
	assign cut_pw    = cut_early ? (rps_q - SUM_W'(cur_q)) : rps_q;
	assign one_s     = (CW + 1)'(1);
	assign pos_s     = $signed({1'b0, pos_q});
	assign cnt_s     = $signed({1'b0, load_cnt_q});
	assign cut_end   = cut_early ? (pos_s - one_s) : pos_s;
	assign fin_end   = cnt_s - one_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			pos_q      <= '0;
			rem_q      <= '0;
			rps_q      <= '0;
			part_q     <= '0;
			k_q        <= PC_MIN;
			ovf_q      <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					load_cnt_q <= load_cnt_q + CW'(1);
					rem_q      <= rem_q + SUM_W'(w_eff);
				end
				if (cmd.start)
					k_q <= k_clamp;
			end
			if (cmd.add)
				rps_q <= rps_q + SUM_W'(rd_data);
			if (cmd.step)
				pos_q <= pos_q + CW'(1);
			if (cmd.cut) begin
				rem_q  <= rem_q - cut_pw;
				part_q <= part_q + PIDX_W'(1);
				rps_q  <= '0;
				if (!cut_early)
					pos_q <= pos_q + CW'(1);
			end
			if (cmd.fin) begin
				load_cnt_q <= '0;
				pos_q      <= '0;
				rem_q      <= '0;
				rps_q      <= '0;
				part_q     <= '0;
				ovf_q      <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add)
			cur_q <= rd_data;
		if (cmd.mul1 || cmd.mul2)
			mul_q <= product;
		if (cmd.cut) begin
			part_index   <= part_q;
			end_position <= POS_W'(cut_end);
			part_weight  <= PW_W'(cut_pw);
			truncated    <= ovf_q;
			last_part    <= 1'b0;
		end else if (cmd.fin) begin
			part_index   <= part_q;
			end_position <= POS_W'(fin_end);
			part_weight  <= PW_W'(rem_q);
			truncated    <= ovf_q;
			last_part    <= 1'b1;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load_cnt_q <= CW'(MAX_LEN))
		else $error("load count past store depth");

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> (pos_q < load_cnt_q))
		else $error("scan read beyond loaded weights");

	a_cut_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cut |-> (({1'b0, part_q} + PC_W'(1)) < k_q))
		else $error("cut beyond requested part count");

endmodule

### tb/greedy_weight_partition_1d_test.sv
// Self-checking testbench for greedy_weight_partition_1d: loads weight sequences, predicts
// every part from a local greedy scan, and compares each result transfer field by field.
// Depends on gwp_pkg, gwp_ifs and the greedy_weight_partition_1d RTL.
module greedy_weight_partition_1d_test;
	import gwp_pkg::*;

	localparam int MAX_LEN       = 1024;
	localparam int MAX_PARTS     = 16;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES   = 400;
	localparam logic [APB_AW-1:0] PARTS_ADDR = {REG_PARTS_COUNT, 2'b00};
	localparam logic [APB_AW-1:0] SPARE_ADDR = {~REG_PARTS_COUNT, 2'b00};

	typedef struct packed {
		logic [PIDX_W-1:0]       part_index;
		logic signed [POS_W-1:0] end_position;
		logic [PW_W-1:0]         part_weight;
		logic                    truncated;
		logic                    last_part;
	} part_t;

	typedef enum int {W_FULL, W_SMALL, W_FLAT, W_SPIKY, W_HEAVY, W_SCALED} wstyle_t;

	class partition_scoreboard;
		logic [WEIGHT_W-1:0] store [MAX_LEN];
		int unsigned         fill;
		longint unsigned     total;
		bit                  dropped;
		logic [PC_W-1:0]     parts_req = PC_RESET;
		part_t               expected[$];
		int unsigned         mismatches, sequences, parts_checked, truncated_seqs, empty_parts;

		function void set_parts(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
			if (addr[2] == REG_PARTS_COUNT)
				parts_req = data[PC_W-1:0];
		endfunction

		function void add_part(int idx, int pos, longint unsigned w, bit fin);
			part_t p;
			p.part_index   = PIDX_W'(idx);
			p.end_position = POS_W'(pos);
			p.part_weight  = PW_W'(w);
			p.truncated    = dropped;
			p.last_part    = fin;
			expected.insert(expected.size(), p);
		endfunction

		// load one weight; on the last one run the greedy scan
		function void note_weight(logic [WEIGHT_W-1:0] w, logic fin);
			int k, n, pos, pc;
			longint unsigned run, cur, r, pw;
			if (fill < MAX_LEN) begin
				store[fill] = w;
				fill++;
				total += w;
			end else begin
				dropped = 1'b1;
			end
			if (!fin)
				return;
			k = parts_req;
			if (k < 2) k = 2;
			if (k > MAX_PARTS) k = MAX_PARTS;
			n = fill;
			pos = 0;
			pc = 0;
			run = 0;
			while (pos < n) begin
				cur = store[pos];
				r = k - pc;
				run += cur;
				if (pc + 1 < k && run * r > total) begin
					if (total * 2 < r * (run * 2 - cur)) begin
						// cut before; same weight is scanned again
						pw = run - cur;
						if (pw == 0) empty_parts++;
						add_part(pc, pos - 1, pw, 1'b0);
						total -= pw;
					end else begin
						add_part(pc, pos, run, 1'b0);
						total -= run;
						pos++;
					end
					pc++;
					run = 0;
				end else begin
					pos++;
				end
			end
			add_part(pc, n - 1, total, 1'b1);
			sequences++;
			if (dropped) truncated_seqs++;
			fill = 0;
			total = 0;
			dropped = 1'b0;
		endfunction

		function bit count_mismatch();
			mismatches++;
			return mismatches <= 10;
		endfunction

		function void check_part(part_t got);
			part_t want;
			parts_checked++;
			if (expected.size() == 0) begin
				if (count_mismatch())
					$display("unexpected part: idx=%0d end=%0d weight=%0d trunc=%0b last=%0b",
						got.part_index, $signed(got.end_position), got.part_weight,
						got.truncated, got.last_part);
				return;
			end
			want = expected.pop_front();
			if (got.part_index !== want.part_index || got.end_position !== want.end_position ||
					got.part_weight !== want.part_weight || got.truncated !== want.truncated ||
					got.last_part !== want.last_part) begin
				if (count_mismatch())
					$display({"part mismatch: exp idx=%0d end=%0d weight=%0d trunc=%0b last=%0b",
						" | got idx=%0d end=%0d weight=%0d trunc=%0b last=%0b"},
						want.part_index, $signed(want.end_position), want.part_weight,
						want.truncated, want.last_part,
						got.part_index, $signed(got.end_position), got.part_weight,
						got.truncated, got.last_part);
			end
		endfunction

		function void check_parts_count(logic [APB_DW-1:0] data);
			if (data[PC_W-1:0] !== parts_req) begin
				if (count_mismatch())
					$display("parts_count readback: expected %0d, got %0d",
						parts_req, data[PC_W-1:0]);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	gwp_in_if  weights_bus();
	gwp_out_if parts_bus();

	partition_scoreboard sb = new;
	int unsigned weights_sent;
	int unsigned hold_requests;
	int unsigned burst_left;
	bit          gaps_on;

	greedy_weight_partition_1d dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.weights (weights_bus),
		.parts   (parts_bus)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// result side: stall level changes per epoch, plus requested long hold-offs
	initial begin : result_sink
		int unsigned held, served, epoch, stall_pct;
		held = 0;
		served = 0;
		epoch = 0;
		stall_pct = 0;
		parts_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (epoch == 0) begin
				epoch = $urandom_range(150, 20);
				case ($urandom_range(4))
					0, 1: stall_pct = 0;
					2: stall_pct = 30;
					3: stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end
			epoch--;
			if (hold_requests != served) begin
				served++;
				held = HOLD_CYCLES;
			end
			if (held != 0) begin
				held--;
				parts_bus.ready <= 1'b0;
			end else begin
				parts_bus.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && parts_bus.valid && parts_bus.ready)
			sb.check_part({parts_bus.part_index, parts_bus.end_position, parts_bus.part_weight,
				parts_bus.truncated, parts_bus.last_part});
	end

	task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_parts(addr, data);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read(input logic [APB_AW-1:0] addr);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.check_parts_count(prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// one weight transfer; bursts with random gaps when gaps_on
	task automatic offer(input logic [WEIGHT_W-1:0] w, input logic fin);
		int unsigned gap;
		if (gaps_on) begin
			if (burst_left == 0) begin
				gap = $urandom_range(12, 1);
				weights_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(16, 1);
			end
			burst_left--;
		end
		weights_bus.valid  <= 1'b1;
		weights_bus.weight <= w;
		weights_bus.last   <= fin;
		do @(posedge clk); while (!weights_bus.ready);
		sb.note_weight(w, fin);
		weights_sent++;
	endtask

	task automatic send_list(input logic [WEIGHT_W-1:0] ws[$]);
		foreach (ws[i])
			offer(ws[i], i == ws.size() - 1);
	endtask

	task automatic send_sequence(input int len, input wstyle_t style);
		logic [WEIGHT_W-1:0] w, base;
		base = $urandom;
		for (int i = 0; i < len; i++) begin
			case (style)
				W_FULL:   w = $urandom;
				W_SMALL:  w = $urandom_range(15);
				W_FLAT:   w = base;
				W_SPIKY:  w = ($urandom_range(7) == 0) ? $urandom : '0;
				W_HEAVY:  w = ($urandom_range(3) == 0) ? '1 : $urandom_range(255);
				default:  w = $urandom >> $urandom_range(31);
			endcase
			offer(w, i == len - 1);
		end
	endtask

	// sender pauses until every part is back, then lets the block go idle
	task automatic settle();
		weights_bus.valid <= 1'b0;
		while (sb.expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned phase, phase_end;
		logic [PC_W-1:0] setting;
		arst_n             <= 1'b0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		weights_bus.valid  <= 1'b0;
		weights_bus.weight <= '0;
		weights_bus.last   <= 1'b0;
		hold_requests      <= 0;
		gaps_on = 1'b0;
		burst_left = 0;
		weights_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_read(PARTS_ADDR);
		reg_write(SPARE_ADDR, 32'd9);
		reg_read(PARTS_ADDR);

		send_list('{32'd0});
		send_list('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_list('{32'd1, 32'd2, 32'd3, 32'd4});
		settle();
		reg_write(PARTS_ADDR, 32'd4);
		send_list('{32'd10, 32'd1, 32'd1});
		send_list('{32'd0, 32'd0, 32'd0, 32'd7});
		send_list('{32'd5, 32'd5, 32'd5, 32'd5, 32'd5});
		settle();
		reg_write(PARTS_ADDR, 32'd16);
		send_list('{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd2, 32'd3});
		settle();

		phase = 0;
		while (weights_sent < 270) begin
			case (phase)
				0: setting = 5'd3;
				1: setting = 5'd16;
				2: setting = 5'd0;
				3: setting = 5'd1;
				4: setting = 5'd31;
				5: setting = 5'd17;
				6: setting = 5'd2;
				default: setting = $urandom_range(31);
			endcase
			reg_write(PARTS_ADDR, APB_DW'(setting));
			reg_read(PARTS_ADDR);
			gaps_on = (phase % 3 != 1);
			if (phase == 1)
				hold_requests <= hold_requests + 1;
			phase_end = weights_sent + 30;
			while (weights_sent < phase_end)
				send_sequence(($urandom_range(5) == 0) ? $urandom_range(48, 13)
					: $urandom_range(12, 1), wstyle_t'($urandom_range(W_SCALED)));
			settle();
			phase++;
		end

		$display("Run covered %0d weights in %0d sequences: %0d parts checked, %0d empty, %0d truncated.",
			weights_sent, sb.sequences, sb.parts_checked, sb.empty_parts, sb.truncated_seqs);
		$display("Part counts from 0 to 31 were used, with bursty input, output stalls and a long hold-off.");
		if (sb.mismatches == 0 && sb.expected.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### files.f
src/gwp_pkg.sv
src/gwp_ifs.sv
src/gwp_ram.sv
src/gwp_ctrl.sv
src/gwp_dp.sv
src/greedy_weight_partition_1d.sv
tb/greedy_weight_partition_1d_test.sv
